### src/tsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the TCP SYN header builder
// Payload structs, configuration indexes, header word order and the
// intermediate record that travels from the front end to the emitter.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int HDR_WORDS      = 10;
    localparam int WORD_IDX_W     = $clog2(HDR_WORDS);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IP_IDENT      = 2'd2;

    localparam logic [15:0] IDENT_RESET = 16'h0100;

    // header constants
    localparam logic [31:0] VER_IHL_TOS_LEN = 32'h4500_0028;
    localparam logic [7:0]  PROTO_TCP       = 8'h06;
    localparam logic [15:0] TCP_LEN         = 16'd20;
    localparam logic [7:0]  TCP_DATA_OFF    = 8'h50;
    localparam logic [7:0]  TCP_FLAG_SYN    = 8'h02;
    localparam logic [7:0]  TTL_BASE        = 8'd50;
    localparam logic [15:0] SPORT_MOD       = 16'd20000;

    typedef enum logic [WORD_IDX_W-1:0] {
        WD_VER_LEN,
        WD_IDENT,
        WD_TTL,
        WD_SRC,
        WD_DST,
        WD_PORTS,
        WD_SEQ,
        WD_ACK,
        WD_FLAGS,
        WD_TCP_CSUM
    } word_idx_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } in_t;

    typedef struct packed {
        logic [31:0] header_word;
        logic        last_word;
    } out_t;

    typedef struct packed {
        logic [31:0] seq_base;
        logic [15:0] src_port_base;
        logic [15:0] ip_ident;
    } cfg_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] seq;
        logic [7:0]  ttl;
        logic [15:0] win;
        logic [15:0] ident;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } job_t;

endpackage

### src/tsb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_front: probe intake and header field pipeline
// Three stages: derived fields, raw checksum sums, checksum fold. The last
// stage pushes a finished job into the queue.
// ----------------------------------------------------------------------------
module tsb_front
    import tsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic push,
    output job_t push_job,
    input  logic q_full
);

    logic advance;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    job_t        s1_job_reg, s2_job_reg, s3_job_reg;
    logic [17:0] s1_addr_sum_reg;
    logic [19:0] s2_ip_raw_reg, s2_tcp_raw_reg;

    job_t        s1_job_next, s2_job_next, s3_job_next;
    logic [17:0] s1_addr_sum_next;
    logic [19:0] s2_ip_raw_next, s2_tcp_raw_next;

    logic [5:0]  nib_sum;
    logic [4:0]  nib_fold;
    logic [2:0]  r5;
    logic [1:0]  k4;
    logic [4:0]  r20;
    logic [15:0] port_m;

    function automatic logic [15:0] csum_fold(input logic [19:0] s);
        logic [16:0] a;
        logic [15:0] b;
        a = {1'b0, s[15:0]} + {13'b0, s[19:16]};
        b = a[15:0] + {15'b0, a[16]};
        return ~b;
    endfunction

    assign advance  = !s3_valid_reg || !q_full;
    assign in_stall = !advance;
    assign push     = s3_valid_reg && !q_full;
    assign push_job = s3_job_reg;

    // stage 1: port mod 20 via mod 4 / mod 5 (16 = 1 mod 5), port mod 20000
    always_comb
    begin
        nib_sum  = 6'(in_data.dst_port[3:0]) + 6'(in_data.dst_port[7:4])
                 + 6'(in_data.dst_port[11:8]) + 6'(in_data.dst_port[15:12]);
        nib_fold = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);
        if (nib_fold >= 5'd15)
            r5 = 3'(nib_fold - 5'd15);
        else if (nib_fold >= 5'd10)
            r5 = 3'(nib_fold - 5'd10);
        else if (nib_fold >= 5'd5)
            r5 = 3'(nib_fold - 5'd5);
        else
            r5 = nib_fold[2:0];
        // CRT: x = r5 + 5k, with 5 = 1 mod 4
        k4  = in_data.dst_port[1:0] - r5[1:0];
        r20 = 5'(r5) + {1'b0, k4, 2'b00} + 5'(k4);

        if (in_data.dst_port >= 16'(3 * 20000))
            port_m = in_data.dst_port - 16'(3 * 20000);
        else if (in_data.dst_port >= 16'(2 * 20000))
            port_m = in_data.dst_port - 16'(2 * 20000);
        else if (in_data.dst_port >= SPORT_MOD)
            port_m = in_data.dst_port - SPORT_MOD;
        else
            port_m = in_data.dst_port;

        s1_job_next          = '0;
        s1_job_next.src_addr = in_data.src_addr;
        s1_job_next.dst_addr = in_data.dst_addr;
        s1_job_next.dst_port = in_data.dst_port;
        s1_job_next.src_port = port_m + cfg.src_port_base;
        s1_job_next.seq      = cfg.seq_base + {15'b0, in_data.dst_port, 1'b0};
        s1_job_next.ttl      = 8'(r20) + TTL_BASE;
        s1_job_next.ident    = cfg.ip_ident;
        s1_addr_sum_next     = 18'(in_data.src_addr[31:16]) + 18'(in_data.src_addr[15:0])
                             + 18'(in_data.dst_addr[31:16]) + 18'(in_data.dst_addr[15:0]);
    end

    // stage 2: raw one's-complement sums
    always_comb
    begin
        s2_job_next     = s1_job_reg;
        s2_job_next.win = {4'(s1_job_reg.ttl[1:0]) + 4'd1, 12'b0} >> 2;
        s2_ip_raw_next  = 20'(s1_addr_sum_reg) + 20'(VER_IHL_TOS_LEN[31:16])
                        + 20'(VER_IHL_TOS_LEN[15:0]) + 20'(s1_job_reg.ident)
                        + 20'({s1_job_reg.ttl, PROTO_TCP});
        s2_tcp_raw_next = 20'(s1_addr_sum_reg) + 20'(PROTO_TCP) + 20'(TCP_LEN)
                        + 20'(s1_job_reg.src_port) + 20'(s1_job_reg.dst_port)
                        + 20'(s1_job_reg.seq[31:16]) + 20'(s1_job_reg.seq[15:0])
                        + 20'({TCP_DATA_OFF, TCP_FLAG_SYN}) + 20'(s2_job_next.win);
    end

    // stage 3: fold and invert
    always_comb
    begin
        s3_job_next          = s2_job_reg;
        s3_job_next.ip_csum  = csum_fold(s2_ip_raw_reg);
        s3_job_next.tcp_csum = csum_fold(s2_tcp_raw_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_job_reg      <= s1_job_next;
            s1_addr_sum_reg <= s1_addr_sum_next;
            s2_job_reg      <= s2_job_next;
            s2_ip_raw_reg   <= s2_ip_raw_next;
            s2_tcp_raw_reg  <= s2_tcp_raw_next;
            s3_job_reg      <= s3_job_next;
        end
    end

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && q_full |=> s3_valid_reg && $stable(s3_job_reg))
        else $error("front: stalled job lost or changed");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s3_valid_reg && q_full)
        else $error("front: stall without a full queue");

    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> s3_valid_reg)
        else $error("front: push without a job");

endmodule

### src/tsb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_queue: small job queue between front end and emitter
// Register-based FIFO; head is visible combinationally.
// ----------------------------------------------------------------------------
module tsb_queue
    import tsb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue: pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue: count out of range");

endmodule

### src/tsb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_back: header word emitter
// Walks the ten header words of the job at the queue head into an output
// register, one word per beat; pops the job as its last word is loaded.
// ----------------------------------------------------------------------------
module tsb_back
    import tsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  job_t head_job,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    word_idx_t   idx_reg, idx_next;
    logic        out_valid_reg;
    out_t        out_data_reg, out_data_next;
    logic        load;

    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && (idx_reg == WD_TCP_CSUM);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_data_next.last_word = (idx_reg == WD_TCP_CSUM);
        case (idx_reg)
            WD_VER_LEN:  out_data_next.header_word = VER_IHL_TOS_LEN;
            WD_IDENT:    out_data_next.header_word = {head_job.ident, 16'h0000};
            WD_TTL:      out_data_next.header_word = {head_job.ttl, PROTO_TCP,
                                                      head_job.ip_csum};
            WD_SRC:      out_data_next.header_word = head_job.src_addr;
            WD_DST:      out_data_next.header_word = head_job.dst_addr;
            WD_PORTS:    out_data_next.header_word = {head_job.src_port, head_job.dst_port};
            WD_SEQ:      out_data_next.header_word = head_job.seq;
            WD_ACK:      out_data_next.header_word = 32'h0000_0000;
            WD_FLAGS:    out_data_next.header_word = {TCP_DATA_OFF, TCP_FLAG_SYN,
                                                      head_job.win};
            WD_TCP_CSUM: out_data_next.header_word = {head_job.tcp_csum, 16'h0000};
            default:     out_data_next.header_word = 32'h0000_0000;
        endcase

        if (idx_reg == WD_TCP_CSUM)
            idx_next = WD_VER_LEN;
        else
            idx_next = word_idx_t'(idx_reg + WORD_IDX_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= WD_VER_LEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != WD_VER_LEN |-> head_valid)
        else $error("back: job left the queue mid-header");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        load && idx_reg == WD_TCP_CSUM |=> idx_reg == WD_VER_LEN)
        else $error("back: word index did not wrap after last word");

    a_last_at_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_data_reg.last_word)
        else $error("back: pop without last word");

endmodule

### src/tcp_syn_packet_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_packet_builder: IPv4 + TCP SYN header generator
// Builds a 40-byte IPv4/TCP SYN header with both Internet checksums for each
// probe and streams it out as ten big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Each accepted probe (source address, destination address, destination
// port) yields ten output beats, IP header first; last_word marks the tenth.
// The word emitter delivers one word per cycle while out_stall is low.
// Probes are taken in back to back while the three-stage field/checksum
// pipeline and the job queue (QUEUE_DEPTH jobs) have room; on an idle
// block a probe passes through the pipeline stages and the job queue
// into the output register, which presents its first word. Registers
// (seq_base, src_port_base, ip_ident) should be written only while no
// probe is in flight.
module tcp_syn_packet_builder
    import tsb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data
);

    cfg_t cfg_reg;
    logic push, pop, q_full, head_valid;
    job_t push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seq_base      <= '0;
            cfg_reg.src_port_base <= '0;
            cfg_reg.ip_ident      <= IDENT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEQ_BASE:      cfg_reg.seq_base      <= cfg_data;
                CFG_SRC_PORT_BASE: cfg_reg.src_port_base <= cfg_data[15:0];
                CFG_IP_IDENT:      cfg_reg.ip_ident      <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    tsb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    tsb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    tsb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

### tb/tsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_checker: header stream scoreboard for the TCP SYN header builder
// Tracks register writes, builds the ten expected header words for every
// accepted probe and compares them with each accepted output beat.
// ----------------------------------------------------------------------------
module tsb_checker
    import tsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_t                  out_data,
    output int                    fail_count,
    output int                    pending
);

    logic [31:0] seq_base_q;
    logic [15:0] sport_base_q;
    logic [15:0] ident_q;
    out_t        header_fifo [$];
    out_t        want;
    int          mism;

    function automatic logic [31:0] add_halves(logic [31:0] acc, logic [31:0] w);
        return acc + {16'h0, w[31:16]} + {16'h0, w[15:0]};
    endfunction

    // end-around carry fold, then one's complement
    function automatic logic [15:0] csum_finish(logic [31:0] acc);
        while (acc > 32'h0000_ffff)
            acc = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
        return ~acc[15:0];
    endfunction

    function automatic void queue_syn_header(in_t probe);
        logic [31:0] w [HDR_WORDS];
        int unsigned port;
        logic [7:0]  ttl;
        logic [15:0] sport;
        logic [15:0] win;
        logic [31:0] acc;
        out_t        beat;
        port  = probe.dst_port;
        ttl   = 8'(port % 20 + 50);
        sport = 16'((port % 20000) + sport_base_q);
        win   = 16'(1024 * (ttl % 4 + 1));

        w[WD_VER_LEN]  = 32'h4500_0028;
        w[WD_IDENT]    = {ident_q, 16'h0000};
        w[WD_TTL]      = {ttl, 8'h06, 16'h0000};
        w[WD_SRC]      = probe.src_addr;
        w[WD_DST]      = probe.dst_addr;
        w[WD_PORTS]    = {sport, probe.dst_port};
        w[WD_SEQ]      = seq_base_q + 32'(2 * port);
        w[WD_ACK]      = 32'h0;
        w[WD_FLAGS]    = {8'h50, 8'h02, win};
        w[WD_TCP_CSUM] = 32'h0;

        acc = 32'h0;
        for (int i = 0; i < 5; i++)
            acc = add_halves(acc, w[i]);
        w[WD_TTL][15:0] = csum_finish(acc);

        // pseudo header: src, dst, zero/protocol, TCP length
        acc = add_halves(32'h0, probe.src_addr);
        acc = add_halves(acc, probe.dst_addr);
        acc = add_halves(acc, 32'h0006_0014);
        for (int i = 5; i < HDR_WORDS; i++)
            acc = add_halves(acc, w[i]);
        w[WD_TCP_CSUM][31:16] = csum_finish(acc);

        for (int i = 0; i < HDR_WORDS; i++)
        begin
            beat.header_word = w[i];
            beat.last_word   = (i == HDR_WORDS - 1);
            header_fifo.push_back(beat);
        end
    endfunction

    task automatic note_mismatch(out_t exp_beat, out_t got_beat, bit none_waiting);
        if (mism < 10)
        begin
            if (none_waiting)
                $display("%0t: unexpected beat %h last %b", $realtime,
                         got_beat.header_word, got_beat.last_word);
            else
                $display("%0t: mismatch, expected %h last %b, got %h last %b", $realtime,
                         exp_beat.header_word, exp_beat.last_word,
                         got_beat.header_word, got_beat.last_word);
        end
        mism++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_base_q   = 32'h0;
            sport_base_q = 16'h0;
            ident_q      = IDENT_RESET;
            header_fifo.delete();
            mism         = 0;
            pending      <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SEQ_BASE:      seq_base_q   = cfg_data;
                    CFG_SRC_PORT_BASE: sport_base_q = cfg_data[15:0];
                    CFG_IP_IDENT:      ident_q      = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                queue_syn_header(in_data);
            if (out_valid && !out_stall)
            begin
                if (header_fifo.size() == 0)
                    note_mismatch(out_data, out_data, 1'b1);
                else
                begin
                    want = header_fifo.pop_front();
                    if (out_data.header_word !== want.header_word ||
                        out_data.last_word !== want.last_word)
                        note_mismatch(want, out_data, 1'b0);
                end
            end
            pending    <= header_fifo.size();
            fail_count <= mism;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the TCP SYN header builder
// Drives directed and random probes across several register settings and
// idling mixes; the checker instance scores every header beat.
// ----------------------------------------------------------------------------
module testbench;
    import tsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int SETS_PER_MIX   = 2;
    localparam int PROBES_PER_SET = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    int                    fail_count;
    int                    pending;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          probes_sent;
    int          words_seen;
    int          settings_used;
    logic [31:0] cur_seq_base;
    logic [15:0] cur_sport_base;
    logic [15:0] cur_ident;

    tcp_syn_packet_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    tsb_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: ends the run after too many cycles without any accepted probe or beat
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        words_seen  = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                words_seen++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog expired with %0d beats pending", pending);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(15))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'd19999;
            3:       return 16'd20000;
            4:       return 16'd40000;
            5:       return 16'd60000;
            default: return 16'($urandom);
        endcase
    endfunction

    // probe whose IP (or TCP) checksum comes out as zero
    function automatic in_t zero_csum_probe(logic [15:0] port, bit tcp_side);
        in_t         p;
        logic [31:0] acc;
        logic [7:0]  ttl;
        logic [15:0] sport;
        logic [15:0] win;
        logic [31:0] seq;
        ttl        = 8'(port % 20 + 50);
        p.dst_port = port;
        if (!tcp_side)
        begin
            p.dst_addr = 32'h0;
            acc = 32'h4500 + 32'h0028 + {16'h0, cur_ident} + {16'h0, ttl, 8'h06};
        end
        else
        begin
            p.src_addr = $urandom;
            sport = 16'((port % 20000) + cur_sport_base);
            seq   = cur_seq_base + 32'(2 * port);
            win   = 16'(1024 * (ttl % 4 + 1));
            acc = {16'h0, p.src_addr[31:16]} + {16'h0, p.src_addr[15:0]} + 32'd26 +
                  {16'h0, sport} + {16'h0, port} + {16'h0, seq[31:16]} +
                  {16'h0, seq[15:0]} + 32'h5002 + {16'h0, win};
        end
        while (acc > 32'h0000_ffff)
            acc = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
        if (!tcp_side)
            p.src_addr = {16'hffff - acc[15:0], 16'h0};
        else
            p.dst_addr = {16'hffff - acc[15:0], 16'h0};
        return p;
    endfunction

    task automatic send_probe(in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        probes_sent++;
    endtask

    // drop valid and wait until every header beat has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SEQ_BASE:      cur_seq_base   = val;
            CFG_SRC_PORT_BASE: cur_sport_base = val[15:0];
            CFG_IP_IDENT:      cur_ident      = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [31:0] seq_b, logic [31:0] sport_b,
                                 logic [31:0] ident);
        write_reg(CFG_SEQ_BASE, seq_b);
        write_reg(CFG_SRC_PORT_BASE, sport_b);
        write_reg(CFG_IP_IDENT, ident);
        settings_used++;
    endtask

    initial
    begin
        in_t p;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SEQ_BASE;
        cfg_data       = 32'h0;
        in_valid       = 1'b0;
        in_data        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        probes_sent    = 0;
        settings_used  = 1;
        cur_seq_base   = 32'h0;
        cur_sport_base = 16'h0;
        cur_ident      = IDENT_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed probes at reset register values
        send_probe(in_t'{32'h0000_0000, 32'h0000_0000, 16'd0});
        send_probe(in_t'{32'hffff_ffff, 32'hffff_ffff, 16'hffff});
        send_probe(in_t'{32'haaaa_aaaa, 32'h5555_5555, 16'haaaa});
        send_probe(in_t'{32'h5555_5555, 32'haaaa_aaaa, 16'h5555});
        send_probe(in_t'{$urandom, $urandom, 16'd1});
        send_probe(in_t'{$urandom, $urandom, 16'd2});
        send_probe(in_t'{$urandom, $urandom, 16'd3});
        send_probe(in_t'{$urandom, $urandom, 16'd19999});
        send_probe(in_t'{$urandom, $urandom, 16'd20000});
        send_probe(in_t'{$urandom, $urandom, 16'd39999});
        send_probe(in_t'{$urandom, $urandom, 16'd40000});
        send_probe(zero_csum_probe(16'd7, 1'b0));
        send_probe(zero_csum_probe(16'd1234, 1'b1));
        settle();

        // out-of-range index is ignored; wide data is truncated
        write_reg(2'd3, $urandom);
        load_settings(32'hffff_ffff, 32'h1234_ffff, 32'hffff_0000);
        send_probe(in_t'{$urandom, $urandom, 16'hffff});
        send_probe(in_t'{$urandom, $urandom, 16'd45535});
        send_probe(in_t'{32'h0000_0000, 32'hffff_ffff, 16'd0});
        send_probe(in_t'{$urandom, $urandom, 16'd60000});
        send_probe(zero_csum_probe(16'd555, 1'b0));
        send_probe(zero_csum_probe(16'hfffe, 1'b1));
        settle();

        // random probes over four idling mixes
        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int s = 0; s < SETS_PER_MIX; s++)
            begin
                load_settings(pick32(), pick32(), pick32());
                for (int n = 0; n < PROBES_PER_SET; n++)
                begin
                    if (n == PROBES_PER_SET / 2)
                        settle();
                    p.src_addr = pick32();
                    p.dst_addr = pick32();
                    p.dst_port = pick_port();
                    send_probe(p);
                end
                settle();
            end
        end

        $display("Sent %0d probes, checked %0d header beats under %0d register settings",
                 probes_sent, words_seen, settings_used);
        $display("Idling mixes: none, sender 72%%, receiver 72%%, both 23%%");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
src/tsb_pkg.sv
src/tsb_front.sv
src/tsb_queue.sv
src/tsb_back.sv
src/tcp_syn_packet_builder.sv
tb/tsb_checker.sv
tb/testbench.sv
